FILE: rtl/blpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_pkg
// Shared types and constants of the button LED pattern controller.
// ----------------------------------------------------------------------------
package blpc_pkg;

   localparam int unsigned PWM_STEPS_DEF = 100;
   localparam int unsigned CSR_IDX_W     = 8;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned TIME_W        = 32;
   localparam int unsigned PERIOD_W      = 16;
   localparam int unsigned BRIGHT_W      = 7;
   localparam int unsigned SOS_POS_W     = 5;

   localparam logic [PERIOD_W-1:0]  LONG_PRESS_RST  = 16'd1000;
   localparam logic [PERIOD_W-1:0]  BASE_PERIOD_RST = 16'd500;
   localparam logic [SOS_POS_W-1:0] SOS_LAST        = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LONG_PRESS  = 8'd0,
      CSR_BASE_PERIOD = 8'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      EV_NONE    = 2'd0,
      EV_SHORT   = 2'd1,
      EV_LONG    = 2'd2,
      EV_RELEASE = 2'd3
   } event_type;

   typedef enum logic [1:0] {
      PAT_STEADY = 2'd0,
      PAT_BREATH = 2'd1,
      PAT_SOS    = 2'd2,
      PAT_DOUBLE = 2'd3
   } pattern_type;

   typedef struct packed {
      logic        led_on;
      event_type   button_event;
      pattern_type pattern_sel;
      logic [1:0]  speed_level;
   } result_type;

   // SOS symbol table: dots and dashes sit on even slots, gaps on odd ones
   function automatic logic sos_on(input logic [SOS_POS_W-1:0] pos);
      logic on;
      on = (pos <= SOS_LAST) && !pos[0];
      return on;
   endfunction

endpackage

FILE: rtl/blpc_rate_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_rate_div
// Two-stage constant divider: base period over the PWM step count, by
// reciprocal multiply and a single correction step.
// ----------------------------------------------------------------------------
module blpc_rate_div #(
   parameter int unsigned PWM_STEPS = blpc_pkg::PWM_STEPS_DEF
) (
   input  logic                           clock,
   input  logic [blpc_pkg::PERIOD_W-1:0]  base,
   output logic [blpc_pkg::PERIOD_W-1:0]  quot
);

   localparam int unsigned PW      = blpc_pkg::PERIOD_W;
   localparam int unsigned RECIP   = (1 << PW) / PWM_STEPS;
   localparam int unsigned PROD_W  = PW + blpc_pkg::BRIGHT_W;

   localparam logic [PW-1:0]     RECIP_C = PW'(RECIP);
   localparam logic [PROD_W-1:0] STEPS_C = PROD_W'(PWM_STEPS);

   logic [2*PW-1:0]   prod;
   logic [PW-1:0]     q0_ff;
   logic [PW-1:0]     base_d_ff;
   logic [PROD_W-1:0] back;
   logic [PROD_W-1:0] rem;
   logic [PW-1:0]     quot_in;
   logic [PW-1:0]     quot_ff;

   // estimate is exact or one low
   assign prod = base * RECIP_C;

   always_comb begin
      back    = PROD_W'(q0_ff) * STEPS_C;
      rem     = PROD_W'(base_d_ff) - back;
      quot_in = (rem >= STEPS_C) ? q0_ff + 1'b1 : q0_ff;
   end

   always_ff @(posedge clock) begin
      q0_ff     <= prod[2*PW-1:PW];
      base_d_ff <= base;
      quot_ff   <= quot_in;
   end

   assign quot = quot_ff;

endmodule

FILE: rtl/blpc_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blpc_out_skid
// Result register with one skid entry, so a request can be taken while
// the previous result still waits.
// ----------------------------------------------------------------------------
module blpc_out_skid (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  blpc_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output blpc_pkg::result_type out_data
);

   logic                 out_valid_ff;
   logic                 out_valid_in;
   blpc_pkg::result_type out_data_ff;
   blpc_pkg::result_type out_data_in;
   logic                 skid_valid_ff;
   logic                 skid_valid_in;
   blpc_pkg::result_type skid_data_ff;
   blpc_pkg::result_type skid_data_in;
   logic                 take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: rtl/button_led_pattern_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_led_pattern_controller
// Press classifier (short, long, release) driving speed level and one of
// four LED patterns: steady toggle, breathing PWM, SOS, double blink.
// ----------------------------------------------------------------------------
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | button_down, ms_tick
//   rsp     | out       | rsp_valid/rsp_stall  | led_on, button_event,
//           |           |                      | pattern_sel, speed_level
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One request per cycle while req_stall is low; its result is registered
// on rsp, or in the skid entry while rsp_stall holds. The single-pass update
// between state and result register sets that rate. req_stall rises when the
// result register and its skid entry are both full, and after reset or any CSR
// write while the breathing step divisor (base period over PWM steps) settles.
// ----------------------------------------------------------------------------
module button_led_pattern_controller #(
   parameter int unsigned PWM_STEPS = blpc_pkg::PWM_STEPS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_button_down,
   input  logic                            req_ms_tick,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_led_on,
   output logic [1:0]                      rsp_button_event,
   output logic [1:0]                      rsp_pattern_sel,
   output logic [1:0]                      rsp_speed_level,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [blpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [blpc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int unsigned TW = blpc_pkg::TIME_W;
   localparam int unsigned PW = blpc_pkg::PERIOD_W;
   localparam int unsigned BW = blpc_pkg::BRIGHT_W;
   localparam int unsigned SW = blpc_pkg::SOS_POS_W;

   localparam logic [BW-1:0] STEPS_C     = BW'(PWM_STEPS);
   localparam logic [1:0]    DIV_SETTLE  = 2'd2;

   // configuration and divider settle
   logic [PW-1:0] long_press_ff, long_press_in;
   logic [PW-1:0] base_period_ff, base_period_in;
   logic [1:0]    settle_ff, settle_in;
   logic [PW-1:0] breath_div;

   // press tracking
   logic [TW-1:0] ms_count_ff, ms_count_in;
   logic [TW-1:0] ms_inc_ff, ms_inc_in;
   logic [TW-1:0] press_start_ff, press_start_in;
   logic          prev_down_ff, prev_down_in;
   logic          long_fired_ff, long_fired_in;
   logic [1:0]    speed_ff, speed_in;
   blpc_pkg::pattern_type pattern_ff, pattern_in;
   logic          led_ff, led_in;

   // pattern state
   logic [TW-1:0] steady_last_ff, steady_last_in;
   logic [TW-1:0] breath_last_ff, breath_last_in;
   logic [BW-1:0] brightness_ff, brightness_in;
   logic          breath_rising_ff, breath_rising_in;
   logic [BW-1:0] pwm_phase_ff, pwm_phase_in;
   logic [SW-1:0] sos_pos_ff, sos_pos_in;
   logic [TW-1:0] sos_last_ff, sos_last_in;
   logic [TW-1:0] double_last_ff, double_last_in;
   logic [1:0]    double_phase_ff, double_phase_in;

   // per-request logic
   logic                  req_accept;
   logic                  skid_full;
   logic [TW-1:0]         ms_next;
   logic [TW-1:0]         hold_ms;
   blpc_pkg::event_type   ev;
   logic [1:0]            speed_new;
   blpc_pkg::pattern_type pattern_new;
   logic [PW-1:0]         period;
   logic [PW-1:0]         breath_thr;
   logic [PW-1:0]         double_thr;
   logic [TW-1:0]         el_steady;
   logic [TW-1:0]         el_breath;
   logic [TW-1:0]         el_sos;
   logic [TW-1:0]         el_double;
   logic [BW-1:0]         bright_step;
   logic [BW:0]           phase_inc;
   logic [SW-1:0]         sos_cur;
   blpc_pkg::result_type  res;
   blpc_pkg::result_type  rsp_data;

   assign csr_ready  = 1'b1;
   assign req_stall  = skid_full || (settle_ff != 2'd0);
   assign req_accept = req_valid && !req_stall;

   blpc_rate_div #(
      .PWM_STEPS (PWM_STEPS)
   ) u_rate_div (
      .clock (clock),
      .base  (base_period_ff),
      .quot  (breath_div)
   );

   always_comb begin
      long_press_in  = long_press_ff;
      base_period_in = base_period_ff;
      settle_in      = (settle_ff != 2'd0) ? settle_ff - 2'd1 : settle_ff;
      if (csr_valid && csr_ready) begin
         settle_in = DIV_SETTLE;
         if (csr_index == blpc_pkg::CSR_LONG_PRESS) begin
            long_press_in = csr_wdata;
         end else if (csr_index == blpc_pkg::CSR_BASE_PERIOD) begin
            base_period_in = csr_wdata;
         end
      end
   end

   always_comb begin
      ms_next = req_ms_tick ? ms_inc_ff : ms_count_ff;
      hold_ms = ms_next - press_start_ff;

      ev = blpc_pkg::EV_NONE;
      if (req_button_down) begin
         if (!prev_down_ff) begin
            ev = blpc_pkg::EV_SHORT;
         end else if (hold_ms >= TW'(long_press_ff) && !long_fired_ff) begin
            ev = blpc_pkg::EV_LONG;
         end
      end else if (prev_down_ff) begin
         ev = blpc_pkg::EV_RELEASE;
      end

      speed_new   = (ev == blpc_pkg::EV_SHORT) ? speed_ff + 2'd1 : speed_ff;
      pattern_new = (ev == blpc_pkg::EV_LONG) ?
                    blpc_pkg::pattern_type'(pattern_ff + 2'd1) : pattern_ff;

      period     = base_period_ff >> speed_new;
      breath_thr = breath_div >> speed_new;
      double_thr = base_period_ff >> ({1'b0, speed_new} + 3'd2);

      el_steady = ms_next - steady_last_ff;
      el_breath = ms_next - breath_last_ff;
      el_sos    = ms_next - sos_last_ff;
      el_double = ms_next - double_last_ff;

      bright_step = breath_rising_ff ? brightness_ff + 1'b1 : brightness_ff - 1'b1;
      phase_inc   = {1'b0, pwm_phase_ff} + 1'b1;
      sos_cur     = (sos_pos_ff <= blpc_pkg::SOS_LAST) ? sos_pos_ff : '0;

      ms_count_in      = ms_count_ff;
      ms_inc_in        = ms_inc_ff;
      press_start_in   = press_start_ff;
      prev_down_in     = prev_down_ff;
      long_fired_in    = long_fired_ff;
      speed_in         = speed_ff;
      pattern_in       = pattern_ff;
      led_in           = led_ff;
      steady_last_in   = steady_last_ff;
      breath_last_in   = breath_last_ff;
      brightness_in    = brightness_ff;
      breath_rising_in = breath_rising_ff;
      pwm_phase_in     = pwm_phase_ff;
      sos_pos_in       = sos_pos_ff;
      sos_last_in      = sos_last_ff;
      double_last_in   = double_last_ff;
      double_phase_in  = double_phase_ff;

      if (req_accept) begin
         ms_count_in  = ms_next;
         ms_inc_in    = ms_next + 1'b1;
         prev_down_in = req_button_down;
         speed_in     = speed_new;
         pattern_in   = pattern_new;
         case (ev)
            blpc_pkg::EV_SHORT: begin
               press_start_in = ms_next;
               long_fired_in  = 1'b0;
            end
            blpc_pkg::EV_LONG: begin
               long_fired_in = 1'b1;
            end
            blpc_pkg::EV_RELEASE: begin
               long_fired_in = 1'b0;
            end
            default: begin
            end
         endcase

         case (pattern_new)
            blpc_pkg::PAT_STEADY: begin
               if (el_steady >= TW'(period)) begin
                  led_in         = !led_ff;
                  steady_last_in = ms_next;
               end
            end
            blpc_pkg::PAT_BREATH: begin
               if (el_breath >= TW'(breath_thr)) begin
                  brightness_in  = bright_step;
                  breath_last_in = ms_next;
                  if (bright_step >= STEPS_C || bright_step == '0) begin
                     breath_rising_in = !breath_rising_ff;
                  end
               end
               pwm_phase_in = (phase_inc >= {1'b0, STEPS_C}) ? '0 : phase_inc[BW-1:0];
               led_in       = pwm_phase_in < brightness_in;
            end
            blpc_pkg::PAT_SOS: begin
               if (el_sos >= TW'(period)) begin
                  led_in      = blpc_pkg::sos_on(sos_cur);
                  sos_last_in = ms_next;
                  sos_pos_in  = (sos_cur == blpc_pkg::SOS_LAST) ? '0 : sos_cur + 1'b1;
               end
            end
            default: begin
               if (el_double >= TW'(double_thr)) begin
                  led_in          = !double_phase_ff[0];
                  double_phase_in = double_phase_ff + 2'd1;
                  double_last_in  = ms_next;
               end
            end
         endcase
      end

      res.led_on       = led_in;
      res.button_event = ev;
      res.pattern_sel  = pattern_new;
      res.speed_level  = speed_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff    <= blpc_pkg::LONG_PRESS_RST;
         base_period_ff   <= blpc_pkg::BASE_PERIOD_RST;
         settle_ff        <= DIV_SETTLE;
         ms_count_ff      <= '0;
         ms_inc_ff        <= TW'(1);
         press_start_ff   <= '0;
         prev_down_ff     <= 1'b0;
         long_fired_ff    <= 1'b0;
         speed_ff         <= '0;
         pattern_ff       <= blpc_pkg::PAT_STEADY;
         led_ff           <= 1'b0;
         steady_last_ff   <= '0;
         breath_last_ff   <= '0;
         brightness_ff    <= '0;
         breath_rising_ff <= 1'b1;
         pwm_phase_ff     <= '0;
         sos_pos_ff       <= '0;
         sos_last_ff      <= '0;
         double_last_ff   <= '0;
         double_phase_ff  <= '0;
      end else begin
         long_press_ff    <= long_press_in;
         base_period_ff   <= base_period_in;
         settle_ff        <= settle_in;
         ms_count_ff      <= ms_count_in;
         ms_inc_ff        <= ms_inc_in;
         press_start_ff   <= press_start_in;
         prev_down_ff     <= prev_down_in;
         long_fired_ff    <= long_fired_in;
         speed_ff         <= speed_in;
         pattern_ff       <= pattern_in;
         led_ff           <= led_in;
         steady_last_ff   <= steady_last_in;
         breath_last_ff   <= breath_last_in;
         brightness_ff    <= brightness_in;
         breath_rising_ff <= breath_rising_in;
         pwm_phase_ff     <= pwm_phase_in;
         sos_pos_ff       <= sos_pos_in;
         sos_last_ff      <= sos_last_in;
         double_last_ff   <= double_last_in;
         double_phase_ff  <= double_phase_in;
      end
   end

   blpc_out_skid u_out_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (res),
      .full      (skid_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_led_on       = rsp_data.led_on;
   assign rsp_button_event = rsp_data.button_event;
   assign rsp_pattern_sel  = rsp_data.pattern_sel;
   assign rsp_speed_level  = rsp_data.speed_level;

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (req_accept && rsp_valid && rsp_stall) |=> req_stall)
      else $error("request taken into a full output stage without stalling");

   a_pattern_on_long: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && pattern_ff != $past(pattern_ff))
         |-> $past(req_accept && ev == blpc_pkg::EV_LONG))
      else $error("pattern changed without a long press");

   a_breath_bounds: assert property (@(posedge clock) disable iff (reset)
      (brightness_ff <= STEPS_C) && (pwm_phase_ff < STEPS_C))
      else $error("breathing brightness or PWM phase out of range");

   a_sos_bound: assert property (@(posedge clock) disable iff (reset)
      sos_pos_ff <= blpc_pkg::SOS_LAST)
      else $error("SOS position past the end of the symbol table");

endmodule
